/* src/tcpbs_pkg.sv */
// Package for the two-class packet batch scheduler: queue sizes, codes,
// payload structs and controller state type; tcpbs_ram does not use it.
package tcpbs_pkg;

  // Queue depths and the widths that follow from them.
  localparam int unsigned NORMAL_DEPTH = 32;
  localparam int unsigned FILE_DEPTH   = 32;
  localparam int unsigned NIDX_W = $clog2(NORMAL_DEPTH);
  localparam int unsigned FIDX_W = $clog2(FILE_DEPTH);
  localparam int unsigned NCNT_W = $clog2(NORMAL_DEPTH + 1);
  localparam int unsigned FCNT_W = $clog2(FILE_DEPTH + 1);

  localparam int unsigned LEN_W = 17;  // entry and batch lengths
  localparam int unsigned K_W   = 6;   // entries chosen in one batch

  // Batch limits.
  localparam logic [7:0]       ID_OFFSET    = 8'h20;
  localparam logic [LEN_W:0]   BIG_LIMIT    = 18'h0F000;
  localparam logic [LEN_W-1:0] FILL_LIMIT   = 17'h0C000;
  localparam logic [15:0]      STARVE_LIMIT = 16'h7FFF;
  localparam logic [LEN_W-1:0] FILE_ROOM    = 17'h04000;
  localparam logic [LEN_W-1:0] ZLIB_LIMIT   = 17'h02000;
  localparam logic [LEN_W-1:0] PLAIN_LIMIT  = 17'd55;
  localparam logic [K_W-1:0]   ENTRY_CAP    = 6'd33;

  // APB register map, one 8-bit register per word.
  localparam int unsigned PADDR_W = 5;
  typedef enum logic [2:0] {
    REG_RAW_DATA_ID     = 3'd0,
    REG_BOARD_PACKET_ID = 3'd1,
    REG_FILE_START_ID   = 3'd2,
    REG_FILE_END_ID     = 3'd3,
    REG_FILE_SIZE_ID    = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NORMAL  = 3'd0,
    ST_FILE    = 3'd1,
    ST_HELD    = 3'd2,
    ST_INVALID = 3'd3,
    ST_FULL    = 3'd4,
    ST_SKIPPED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CODEC_PLAIN = 2'd0,
    CODEC_ZLIB  = 2'd1,
    CODEC_BZ2   = 2'd2
  } codec_e;

  typedef enum logic [0:0] {
    MODE_ENQUEUE = 1'b0,
    MODE_SEND    = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  first_byte;
    logic [15:0] packet_length;
    logic [15:0] raw_size;
    logic        chunk_end;
    logic        link_up;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       status;
    logic             from_file_queue;
    logic [LEN_W-1:0] entry_length;
    logic [LEN_W-1:0] batch_length;
    logic [1:0]       codec_choice;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_T_START,
    S_T_LOOP,
    S_T_FILE,
    S_T_SUM
  } state_e;

endpackage

/* src/tcpbs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module tcpbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/two_class_packet_batch_scheduler.sv */
// Top level of the two-class packet batch scheduler: queue controller,
// APB registers and two length RAMs. Depends on tcpbs_pkg and tcpbs_ram.
//
//   Channel | Direction | Handshake                   | Payload
//   --------+-----------+-----------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o     | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i   | out_data_o (out_item_t)
//   cfg     | input     | psel, penable, pwrite, ready| paddr, pwdata, prdata
//
// S_IDLE accepts an enqueue; S_ENQ updates the queue RAM and produces its
// status. A send tick runs S_T_START, S_T_LOOP, S_T_FILE, S_T_SUM; each queue
// RAM has a single read port and delivers one head per cycle unless the output
// stalls. Reset clears the counters, pointers and flags at once; the RAM
// contents are not cleared, because only written entries are ever read. A
// stall on the output holds the controller in place while the output register
// is full; the input is stalled whenever an item is in progress.
module two_class_packet_batch_scheduler
  import tcpbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  // Result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; pready is
  // tied high, so no access is ever extended by wait states.
  // ---------------------------------------------------------------------------
  logic [7:0] raw_id_q, board_id_q, fstart_id_q, fend_id_q, fsize_id_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_id_q    <= 8'd100;
      board_id_q  <= 8'd101;
      fstart_id_q <= 8'd68;
      fend_id_q   <= 8'd69;
      fsize_id_q  <= 8'd84;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_RAW_DATA_ID:     raw_id_q    <= pwdata[7:0];
        REG_BOARD_PACKET_ID: board_id_q  <= pwdata[7:0];
        REG_FILE_START_ID:   fstart_id_q <= pwdata[7:0];
        REG_FILE_END_ID:     fend_id_q   <= pwdata[7:0];
        REG_FILE_SIZE_ID:    fsize_id_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_RAW_DATA_ID:     prdata = {24'd0, raw_id_q};
      REG_BOARD_PACKET_ID: prdata = {24'd0, board_id_q};
      REG_FILE_START_ID:   prdata = {24'd0, fstart_id_q};
      REG_FILE_END_ID:     prdata = {24'd0, fend_id_q};
      REG_FILE_SIZE_ID:    prdata = {24'd0, fsize_id_q};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State registers.
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  in_item_t          item_q;
  logic [NIDX_W-1:0] nhead_q, nhead_d, ntail_q, ntail_d;
  logic [FIDX_W-1:0] fhead_q, fhead_d, ftail_q, ftail_d;
  logic [NCNT_W-1:0] ncount_q, ncount_d;
  logic [FCNT_W-1:0] fcount_q, fcount_d;
  logic              hdr_pend_q, hdr_pend_d;
  logic [15:0]       hdr_len_q, hdr_len_d;
  logic [15:0]       pay_size_q, pay_size_d;
  logic [15:0]       bsf_q, bsf_d;       // bytes sent since the last file entry
  logic              discard_q, discard_d;
  logic [LEN_W-1:0]  total_q, total_d;   // running batch length
  logic [K_W-1:0]    k_q, k_d;           // entries chosen so far in this batch
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // RAM ports. Reads are addressed with the next head pointer, so the read
  // data holds the entry that the head pointer register points at.
  logic              n_we, f_we, n_pop, f_pop;
  logic [LEN_W-1:0]  wlen;
  logic [LEN_W-1:0]  n_rdata, f_rdata;

  tcpbs_ram #(
    .WIDTH(LEN_W),
    .DEPTH(NORMAL_DEPTH)
  ) u_normal_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(ntail_q),
    .wdata_i(wlen),
    .raddr_i(nhead_d),
    .rdata_o(n_rdata)
  );

  tcpbs_ram #(
    .WIDTH(LEN_W),
    .DEPTH(FILE_DEPTH)
  ) u_file_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(ftail_q),
    .wdata_i(wlen),
    .raddr_i(fhead_d),
    .rdata_o(f_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshakes. The output register frees its slot in the same cycle it is
  // taken, so a new result can be loaded behind a transfer.
  // ---------------------------------------------------------------------------
  logic in_accept, slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Derived values used by the controller.
  // ---------------------------------------------------------------------------
  logic [7:0]       dec_id;
  logic [LEN_W-1:0] merged_len;
  logic [LEN_W:0]   n_sum, f_sum;
  logic [LEN_W:0]   bsf_sum;
  logic             n_full, f_full, n_empty, f_empty;
  logic [NIDX_W-1:0] nhead_nx, ntail_nx;
  logic [FIDX_W-1:0] fhead_nx, ftail_nx;
  codec_e           codec;

  assign dec_id     = item_q.first_byte - ID_OFFSET;
  assign merged_len = {1'b0, hdr_len_q} + {1'b0, pay_size_q};
  assign n_sum      = {1'b0, total_q} + {1'b0, n_rdata};
  assign f_sum      = {1'b0, total_q} + {1'b0, f_rdata};
  assign bsf_sum    = {2'b00, bsf_q} + {1'b0, total_q};
  assign n_full     = (ncount_q == NCNT_W'(NORMAL_DEPTH));
  assign f_full     = (fcount_q == FCNT_W'(FILE_DEPTH));
  assign n_empty    = (ncount_q == '0);
  assign f_empty    = (fcount_q == '0);

  assign nhead_nx = (nhead_q == NIDX_W'(NORMAL_DEPTH - 1)) ? '0 : nhead_q + NIDX_W'(1);
  assign ntail_nx = (ntail_q == NIDX_W'(NORMAL_DEPTH - 1)) ? '0 : ntail_q + NIDX_W'(1);
  assign fhead_nx = (fhead_q == FIDX_W'(FILE_DEPTH - 1)) ? '0 : fhead_q + FIDX_W'(1);
  assign ftail_nx = (ftail_q == FIDX_W'(FILE_DEPTH - 1)) ? '0 : ftail_q + FIDX_W'(1);

  always_comb begin
    if (total_q > ZLIB_LIMIT) begin
      codec = CODEC_BZ2;
    end else if (total_q > PLAIN_LIMIT) begin
      codec = CODEC_ZLIB;
    end else begin
      codec = CODEC_PLAIN;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller: next state, queue updates and result generation.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic    to_file;
    status_e st;

    to_file     = 1'b0;
    st          = ST_NORMAL;
    state_d     = state_q;
    ntail_d     = ntail_q;
    ftail_d     = ftail_q;
    ncount_d    = ncount_q;
    fcount_d    = fcount_q;
    hdr_pend_d  = hdr_pend_q;
    hdr_len_d   = hdr_len_q;
    pay_size_d  = pay_size_q;
    bsf_d       = bsf_q;
    discard_d   = discard_q;
    total_d     = total_q;
    k_d         = k_q;
    n_we        = 1'b0;
    f_we        = 1'b0;
    n_pop       = 1'b0;
    f_pop       = 1'b0;
    wlen        = {1'b0, item_q.packet_length};
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (in_data_i.mode == MODE_SEND) ? S_T_START : S_ENQ;
          total_d = '0;
          k_d     = '0;
        end
      end

      S_ENQ: begin
        if (slot_free) begin
          if (discard_q) begin
            st = ST_SKIPPED;
            if (item_q.chunk_end) begin
              discard_d = 1'b0;
            end
          end else if (item_q.first_byte < ID_OFFSET) begin
            st        = ST_INVALID;
            discard_d = !item_q.chunk_end;
          end else if (dec_id == raw_id_q) begin
            st         = ST_HELD;
            hdr_pend_d = 1'b1;
            hdr_len_d  = item_q.packet_length;
            pay_size_d = item_q.raw_size;
          end else begin
            if (hdr_pend_q) begin
              // Payload of a held header: merged length, routed by its own id.
              hdr_pend_d = 1'b0;
              to_file    = (dec_id != board_id_q);
              wlen       = merged_len;
            end else begin
              to_file = (dec_id == fstart_id_q) || (dec_id == fend_id_q) ||
                        (dec_id == fsize_id_q);
            end
            if (to_file) begin
              if (f_full) begin
                st = ST_FULL;
              end else begin
                st       = ST_FILE;
                f_we     = 1'b1;
                ftail_d  = ftail_nx;
                fcount_d = fcount_q + FCNT_W'(1);
              end
            end else begin
              if (n_full) begin
                st = ST_FULL;
              end else begin
                st       = ST_NORMAL;
                n_we     = 1'b1;
                ntail_d  = ntail_nx;
                ncount_d = ncount_q + NCNT_W'(1);
              end
            end
          end
          out_valid_d  = 1'b1;
          out_d        = '0;
          out_d.kind   = KIND_STATUS;
          out_d.status = st;
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_T_START: begin
        if (slot_free) begin
          if (!item_q.link_up) begin
            // Link down: an empty summary and no state change.
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.kind  = KIND_SUMMARY;
            out_d.last  = 1'b1;
            state_d     = S_IDLE;
          end else if (!n_empty && ({1'b0, n_rdata} > BIG_LIMIT)) begin
            // An oversized normal entry goes out alone.
            n_pop              = 1'b1;
            ncount_d           = ncount_q - NCNT_W'(1);
            total_d            = n_rdata;
            k_d                = k_q + K_W'(1);
            out_valid_d        = 1'b1;
            out_d              = '0;
            out_d.kind         = KIND_ENTRY;
            out_d.entry_length = n_rdata;
            state_d            = S_T_LOOP;
          end else if ((bsf_q > STARVE_LIMIT) && !f_empty) begin
            // The file queue has waited too long: force its head out.
            f_pop                 = 1'b1;
            fcount_d              = fcount_q - FCNT_W'(1);
            bsf_d                 = '0;
            total_d               = f_rdata;
            k_d                   = k_q + K_W'(1);
            out_valid_d           = 1'b1;
            out_d                 = '0;
            out_d.kind            = KIND_ENTRY;
            out_d.from_file_queue = 1'b1;
            out_d.entry_length    = f_rdata;
            state_d               = S_T_LOOP;
          end else begin
            state_d = S_T_LOOP;
          end
        end
      end

      S_T_LOOP: begin
        if (slot_free) begin
          if ((total_q < FILL_LIMIT) && !n_empty && (k_q < ENTRY_CAP) &&
              (n_sum <= BIG_LIMIT)) begin
            n_pop              = 1'b1;
            ncount_d           = ncount_q - NCNT_W'(1);
            total_d            = n_sum[LEN_W-1:0];
            k_d                = k_q + K_W'(1);
            out_valid_d        = 1'b1;
            out_d              = '0;
            out_d.kind         = KIND_ENTRY;
            out_d.entry_length = n_rdata;
          end else begin
            bsf_d   = (bsf_sum > {3'b000, 16'hFFFF}) ? 16'hFFFF : bsf_sum[15:0];
            state_d = S_T_FILE;
          end
        end
      end

      S_T_FILE: begin
        if (slot_free) begin
          if ((total_q < FILE_ROOM) && !f_empty && (f_sum <= BIG_LIMIT)) begin
            f_pop                 = 1'b1;
            fcount_d              = fcount_q - FCNT_W'(1);
            bsf_d                 = '0;
            total_d               = f_sum[LEN_W-1:0];
            k_d                   = k_q + K_W'(1);
            out_valid_d           = 1'b1;
            out_d                 = '0;
            out_d.kind            = KIND_ENTRY;
            out_d.from_file_queue = 1'b1;
            out_d.entry_length    = f_rdata;
          end
          state_d = S_T_SUM;
        end
      end

      S_T_SUM: begin
        if (slot_free) begin
          if (f_empty) begin
            bsf_d = '0;
          end
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.kind         = KIND_SUMMARY;
          out_d.batch_length = total_q;
          out_d.codec_choice = codec;
          out_d.last         = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign nhead_d = n_pop ? nhead_nx : nhead_q;
  assign fhead_d = f_pop ? fhead_nx : fhead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nhead_q     <= '0;
      ntail_q     <= '0;
      fhead_q     <= '0;
      ftail_q     <= '0;
      ncount_q    <= '0;
      fcount_q    <= '0;
      hdr_pend_q  <= 1'b0;
      hdr_len_q   <= '0;
      pay_size_q  <= '0;
      bsf_q       <= '0;
      discard_q   <= 1'b0;
      total_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nhead_q     <= nhead_d;
      ntail_q     <= ntail_d;
      fhead_q     <= fhead_d;
      ftail_q     <= ftail_d;
      ncount_q    <= ncount_d;
      fcount_q    <= fcount_d;
      hdr_pend_q  <= hdr_pend_d;
      hdr_len_q   <= hdr_len_d;
      pay_size_q  <= pay_size_d;
      bsf_q       <= bsf_d;
      discard_q   <= discard_d;
      total_q     <= total_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_ncount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncount_q <= NCNT_W'(NORMAL_DEPTH))
    else $error("normal queue count above its depth");

  a_fcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= FCNT_W'(FILE_DEPTH))
    else $error("file queue count above its depth");

  a_write_only_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_we || f_we) |-> (state_q == S_ENQ && !(n_pop || f_pop)))
    else $error("queue RAM written outside an enqueue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_pop |-> !n_empty) and (f_pop |-> !f_empty))
    else $error("pop from an empty queue");

  a_batch_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= ENTRY_CAP + K_W'(2))
    else $error("batch holds too many entries");

endmodule

/* test/tcpbs_checker.sv */
// Scoreboard for the two-class packet batch scheduler. It follows the register
// writes and both queues, predicts every result of each accepted transfer and
// compares the results in order. Depends on tcpbs_pkg for payloads and codes.
`timescale 1ns / 1ps

module tcpbs_checker
  import tcpbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_data_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 pending_o,
  output int                 fails_o
);

  localparam logic [7:0]  ID_BASE     = 8'h20;
  localparam int unsigned BATCH_CEIL  = 'hF000;  // also the lone-head threshold
  localparam int unsigned FILL_STOP   = 'hC000;
  localparam int unsigned STARVED     = 'h7FFF;
  localparam int unsigned FILE_SLOT   = 'h4000;
  localparam int unsigned ZLIB_MAX    = 'h2000;
  localparam int unsigned PLAIN_MAX   = 55;
  localparam int unsigned MAX_ENTRIES = 33;
  localparam int unsigned SAT16       = 'hFFFF;
  localparam int unsigned MAX_REPORTS = 10;

  logic [7:0]       raw_id, board_id, start_id, end_id, size_id;
  logic [LEN_W-1:0] normal_q[$];
  logic [LEN_W-1:0] file_q[$];
  logic             header_held;
  logic [15:0]      header_len, header_size;
  logic             dropping;
  int unsigned      since_file;
  out_item_t        awaited[$];
  int               fail_count = 0;

  function automatic out_item_t result_of(kind_e kind, status_e st, logic ff,
                                          int unsigned elen, int unsigned blen,
                                          codec_e codec, logic last);
    out_item_t r;
    r.kind            = kind;
    r.status          = st;
    r.from_file_queue = ff;
    r.entry_length    = LEN_W'(elen);
    r.batch_length    = LEN_W'(blen);
    r.codec_choice    = codec;
    r.last            = last;
    return r;
  endfunction

  function automatic status_e queue_length(logic to_file, int unsigned len);
    if (to_file) begin
      if (file_q.size() >= FILE_DEPTH) return ST_FULL;
      file_q.push_back(LEN_W'(len));
      return ST_FILE;
    end
    if (normal_q.size() >= NORMAL_DEPTH) return ST_FULL;
    normal_q.push_back(LEN_W'(len));
    return ST_NORMAL;
  endfunction

  task automatic take_packet(in_item_t it);
    status_e    st;
    logic [7:0] id;
    if (dropping) begin
      st = ST_SKIPPED;
      if (it.chunk_end) dropping = 1'b0;
    end else if (it.first_byte < ID_BASE) begin
      st = ST_INVALID;
      dropping = !it.chunk_end;
    end else begin
      id = it.first_byte - ID_BASE;
      if (id == raw_id) begin
        header_held = 1'b1;
        header_len  = it.packet_length;
        header_size = it.raw_size;
        st = ST_HELD;
      end else if (header_held) begin
        // The payload rides on the held header and is routed by its own id.
        header_held = 1'b0;
        st = queue_length(id != board_id, int'(header_len) + int'(header_size));
      end else begin
        st = queue_length(id == start_id || id == end_id || id == size_id,
                          it.packet_length);
      end
    end
    awaited.push_back(result_of(KIND_STATUS, st, 1'b0, 0, 0, CODEC_PLAIN, 1'b1));
  endtask

  task automatic add_entry(logic ff, int unsigned len);
    awaited.push_back(result_of(KIND_ENTRY, ST_NORMAL, ff, len, 0, CODEC_PLAIN, 1'b0));
  endtask

  task automatic form_batch(logic link);
    int unsigned total, e, k;
    codec_e      codec;
    if (!link) begin
      awaited.push_back(result_of(KIND_SUMMARY, ST_NORMAL, 1'b0, 0, 0, CODEC_PLAIN, 1'b1));
      return;
    end
    total = 0;
    k     = 0;
    if (normal_q.size() != 0 && normal_q[0] > BATCH_CEIL) begin
      e = normal_q.pop_front();
      total += e;
      add_entry(1'b0, e);
      k++;
    end
    // A starved file queue gets its head out before any normal filling.
    if (total == 0 && since_file > STARVED && file_q.size() != 0) begin
      e = file_q.pop_front();
      since_file = 0;
      total += e;
      add_entry(1'b1, e);
      k++;
    end
    while (total < FILL_STOP && normal_q.size() != 0 && k < MAX_ENTRIES) begin
      e = normal_q[0];
      if (total + e > BATCH_CEIL) break;
      e = normal_q.pop_front();
      total += e;
      add_entry(1'b0, e);
      k++;
    end
    since_file += total;
    if (since_file > SAT16) since_file = SAT16;
    if (total < FILE_SLOT && file_q.size() != 0) begin
      e = file_q[0];
      if (total + e <= BATCH_CEIL) begin
        e = file_q.pop_front();
        since_file = 0;
        total += e;
        add_entry(1'b1, e);
      end
    end
    if (file_q.size() == 0) since_file = 0;
    if (total > ZLIB_MAX) codec = CODEC_BZ2;
    else if (total > PLAIN_MAX) codec = CODEC_ZLIB;
    else codec = CODEC_PLAIN;
    awaited.push_back(result_of(KIND_SUMMARY, ST_NORMAL, 1'b0, 0, total, codec, 1'b1));
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    logic      bad;
    if (awaited.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected result kind=%0d, nothing awaited", $time, got.kind);
      return;
    end
    want = awaited.pop_front();
    bad = (got.kind !== want.kind) || (got.status !== want.status) ||
          (got.from_file_queue !== want.from_file_queue) ||
          (got.entry_length !== want.entry_length) ||
          (got.batch_length !== want.batch_length) ||
          (got.codec_choice !== want.codec_choice) || (got.last !== want.last);
    if (bad) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: mismatch, expected kind=%0d st=%0d ff=%0d elen=%0h blen=%0h cod=%0d last=%0d",
                 $time, want.kind, want.status, want.from_file_queue, want.entry_length,
                 want.batch_length, want.codec_choice, want.last);
        $display("%0t:             got kind=%0d st=%0d ff=%0d elen=%0h blen=%0h cod=%0d last=%0d",
                 $time, got.kind, got.status, got.from_file_queue, got.entry_length,
                 got.batch_length, got.codec_choice, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_id      = 8'd100;
      board_id    = 8'd101;
      start_id    = 8'd68;
      end_id      = 8'd69;
      size_id     = 8'd84;
      normal_q.delete();
      file_q.delete();
      awaited.delete();
      header_held = 1'b0;
      header_len  = '0;
      header_size = '0;
      dropping    = 1'b0;
      since_file  = 0;
      pending_o  <= 0;
      fails_o    <= fail_count;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_RAW_DATA_ID:     raw_id   = pwdata[7:0];
          REG_BOARD_PACKET_ID: board_id = pwdata[7:0];
          REG_FILE_START_ID:   start_id = pwdata[7:0];
          REG_FILE_END_ID:     end_id   = pwdata[7:0];
          REG_FILE_SIZE_ID:    size_id  = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.mode == MODE_SEND) form_batch(in_data_i.link_up);
        else take_packet(in_data_i);
      end
      pending_o <= awaited.size();
      fails_o   <= fail_count;
    end
  end

endmodule

/* test/two_class_packet_batch_scheduler_test.sv */
// Top of the scheduler testbench: clock, reset, register writes, packet and
// send-tick stimulus with random gaps and output stalls, and the verdict.
// Depends on tcpbs_pkg, the scheduler RTL and tcpbs_checker.
`timescale 1ns / 1ps

module two_class_packet_batch_scheduler_test;
  import tcpbs_pkg::*;

  // The limit is well above the slowest correct run, so only a hang gets
  // here.
  localparam int unsigned RUN_LIMIT_NS  = 15_000_000;
  // The controller returns to idle as it loads the last result of a transfer,
  // so waiting SETTLE_CYCLES after that result leaves the controller idle.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_GAP       = 14;
  localparam logic [7:0]  ID_BASE       = 8'h20;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;
  int                 pending, fails;

  // When set, neither side inserts gaps; it is flipped now and then so that
  // back-to-back stretches alternate with heavily idled ones.
  logic               no_idle;
  // The ids as last written, so that the stimulus can aim at each routing.
  logic [7:0]         id_cfg [5];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_class_packet_batch_scheduler dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  tcpbs_checker result_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending_o  (pending),
    .fails_o    (fails)
  );

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Lengths lean small so that batches pack many entries, with enough large
  // ones to hit the fill limits, lone heads and file starvation.
  function automatic logic [15:0] draw_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(1, 64);
      4, 5:       return $urandom_range(65, 'h2000);
      6, 7:       return $urandom_range('h3000, 'h9000);
      8:          return $urandom_range('hA000, 'hFFFF);
      default:    return $urandom_range(1, 'hFFFF);
    endcase
  endfunction

  function automatic logic [7:0] byte_of(logic [7:0] id);
    return id + ID_BASE;
  endfunction

  // Link state does not matter to an enqueue, so it is left random.
  function automatic in_item_t packet(logic [7:0] fb, logic [15:0] plen,
                                      logic [15:0] rsize, logic cend);
    in_item_t it;
    it.mode          = MODE_ENQUEUE;
    it.first_byte    = fb;
    it.packet_length = plen;
    it.raw_size      = rsize;
    it.chunk_end     = cend;
    it.link_up       = $urandom_range(0, 1);
    return it;
  endfunction

  // Only the link bit matters to a send tick; the rest is noise.
  function automatic in_item_t tick(logic link);
    in_item_t it;
    it.mode          = MODE_SEND;
    it.first_byte    = $urandom_range(0, 255);
    it.packet_length = $urandom_range(1, 'hFFFF);
    it.raw_size      = $urandom_range(0, 'hFFFF);
    it.chunk_end     = $urandom_range(0, 1);
    it.link_up       = link;
    return it;
  endfunction

  // Called at a rising edge. Valid is dropped only when a gap is drawn, so a
  // back-to-back transfer keeps valid high without a glitch in the same step.
  task automatic drive_item(in_item_t it);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Setup phase, access phase, then a return to idle so that back-to-back
  // writes never assign psel twice in one step.
  task automatic write_reg(reg_idx_e idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    id_cfg[idx] = value;
  endtask

  task automatic set_ids(logic [7:0] raw, logic [7:0] board, logic [7:0] fstart,
                         logic [7:0] fend, logic [7:0] fsize);
    write_reg(REG_RAW_DATA_ID, raw);
    write_reg(REG_BOARD_PACKET_ID, board);
    write_reg(REG_FILE_START_ID, fstart);
    write_reg(REG_FILE_END_ID, fend);
    write_reg(REG_FILE_SIZE_ID, fsize);
  endtask

  // The checker's count is registered, so the loop waits for an edge before
  // its first look. Then the controller gets time to return to idle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: normal and file packets, header and payload
  // pairs, invalid bytes followed by the rest of their chunk, and send ticks.
  // A low tick share floods the queues so that full drops show up.
  task automatic random_phase(int unsigned count, int unsigned tick_pct);
    int unsigned done, pick, extra;
    logic [7:0]  id;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
        drive_item(tick($urandom_range(0, 9) != 0));
        done++;
      end else if (pick < tick_pct + 15) begin
        // A raw header, sometimes replaced by a second one, then its payload.
        drive_item(packet(byte_of(id_cfg[REG_RAW_DATA_ID]), draw_length(),
                          $urandom_range(0, 'hFFFF), $urandom_range(0, 1)));
        done++;
        if ($urandom_range(0, 4) == 0) begin
          drive_item(packet(byte_of(id_cfg[REG_RAW_DATA_ID]), draw_length(),
                            draw_length(), $urandom_range(0, 1)));
          done++;
        end
        case ($urandom_range(0, 3))
          0, 1:    id = id_cfg[REG_BOARD_PACKET_ID];
          2:       id = id_cfg[REG_FILE_START_ID];
          default: id = $urandom_range(0, 223);
        endcase
        drive_item(packet(byte_of(id), draw_length(), $urandom_range(0, 'hFFFF),
                          $urandom_range(0, 1)));
        done++;
      end else if (pick < tick_pct + 25) begin
        // An invalid byte; unless it closes its chunk, the rest is skipped.
        extra = $urandom_range(0, 3);
        drive_item(packet($urandom_range(0, 31), $urandom_range(1, 'hFFFF),
                          $urandom_range(0, 'hFFFF), extra == 0));
        done++;
        for (int unsigned i = 0; i < extra; i++) begin
          drive_item(packet($urandom_range(0, 255), draw_length(),
                            $urandom_range(0, 'hFFFF), i == extra - 1));
          done++;
        end
      end else if (pick < tick_pct + 45) begin
        case ($urandom_range(0, 2))
          0:       id = id_cfg[REG_FILE_START_ID];
          1:       id = id_cfg[REG_FILE_END_ID];
          default: id = id_cfg[REG_FILE_SIZE_ID];
        endcase
        drive_item(packet(byte_of(id), draw_length(), $urandom_range(0, 'hFFFF),
                          $urandom_range(0, 1)));
        done++;
      end else if (pick < tick_pct + 50) begin
        drive_item(packet($urandom_range(0, 255), $urandom_range(1, 'hFFFF),
                          $urandom_range(0, 'hFFFF), $urandom_range(0, 1)));
        done++;
      end else begin
        drive_item(packet(byte_of($urandom_range(0, 223)), draw_length(),
                          $urandom_range(0, 'hFFFF), $urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  // Result side: a stall of random length before each transfer.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = idle_cycles();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    no_idle  = 1'b0;
    id_cfg   = '{8'd100, 8'd101, 8'd68, 8'd69, 8'd84};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset ids. An empty batch, then a tick with
    // the link down.
    drive_item(tick(1'b1));
    drive_item(tick(1'b0));
    // Shortest and longest packets at the lowest and highest ids.
    drive_item(packet(8'h20, 16'd1, 16'h0000, 1'b0));
    drive_item(packet(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // One packet for each file id.
    drive_item(packet(byte_of(id_cfg[REG_FILE_START_ID]), 16'h0100, 16'h1234, 1'b0));
    drive_item(packet(byte_of(id_cfg[REG_FILE_END_ID]), 16'd55, 16'h0000, 1'b0));
    drive_item(packet(byte_of(id_cfg[REG_FILE_SIZE_ID]), 16'h2000, 16'hFFFF, 1'b1));
    // The long normal packet does not fit after the short one, so the file
    // head joins instead. Next the long one goes out alone and saturates the
    // starvation counter, so the third tick forces the file head out.
    drive_item(tick(1'b1));
    drive_item(tick(1'b1));
    drive_item(tick(1'b1));
    // An invalid byte mid-chunk drops the rest of that chunk.
    drive_item(packet(8'h1F, 16'd10, 16'h0000, 1'b0));
    drive_item(packet(8'h40, 16'd10, 16'h0000, 1'b0));
    drive_item(packet(8'h00, 16'd10, 16'h0000, 1'b1));
    // An invalid byte that ends its chunk drops only itself.
    drive_item(packet(8'h00, 16'd10, 16'h0000, 1'b1));
    // A header overwritten by a second one, then a board payload whose own
    // length is ignored.
    drive_item(packet(byte_of(id_cfg[REG_RAW_DATA_ID]), 16'hFFFF, 16'hFFFF, 1'b0));
    drive_item(packet(byte_of(id_cfg[REG_RAW_DATA_ID]), 16'd10, 16'h0000, 1'b0));
    drive_item(packet(byte_of(id_cfg[REG_BOARD_PACKET_ID]), 16'd500, 16'h0000, 1'b0));
    // The largest merged entry, sent to the file queue by a non-board payload.
    drive_item(packet(byte_of(id_cfg[REG_RAW_DATA_ID]), 16'hFFFF, 16'hFFFF, 1'b0));
    drive_item(packet(byte_of(8'd5), 16'd1, 16'h0000, 1'b1));
    drive_item(packet(byte_of(id_cfg[REG_RAW_DATA_ID]), 16'h8000, 16'h0000, 1'b0));
    drive_item(packet(byte_of(id_cfg[REG_BOARD_PACKET_ID]), 16'd3, 16'h0000, 1'b1));
    // The big file entry never fits, so it leaves only once starvation
    // forces it, as the largest batch.
    drive_item(tick(1'b1));
    drive_item(tick(1'b1));
    // Codec edges: exactly 55 bytes, then just above the zlib range.
    drive_item(packet(8'h20, 16'd55, 16'h0000, 1'b1));
    drive_item(tick(1'b1));
    drive_item(packet(8'h20, 16'h2001, 16'h0000, 1'b1));
    drive_item(tick(1'b1));
    settle();

    random_phase(120, 10);
    settle();
    // Lowest ids: every id collapses onto the header id.
    set_ids(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    random_phase(80, 25);
    settle();
    // Highest ids with rare ticks, so the queues fill up.
    set_ids(8'd223, 8'd223, 8'd223, 8'd223, 8'd223);
    random_phase(100, 5);
    settle();
    set_ids($urandom_range(0, 223), $urandom_range(0, 223), $urandom_range(0, 223),
            $urandom_range(0, 223), $urandom_range(0, 223));
    random_phase(150, 15);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
